// ===== rtl/mrrd_pkg.sv =====
// ----------------------------------------------------------------------------
// mrrd_pkg
// Shared types and constants of the meter register response decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package mrrd_pkg;

	localparam int MAX_MANTISSA_BYTES = 4;

	localparam logic [7:0] PREFIX_BYTE  = 8'h01;
	localparam logic [7:0] EXP_MAG_MASK = 8'h3F;
	localparam int         EXP_SIGN_POS = 6;
	localparam int         EXP_NEG_POS  = 7;

	localparam logic [3:0] POS_MAX = 4'd15;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_EMPTY     = 3'd1,
		ST_TOO_SMALL = 3'd2,
		ST_BAD_COUNT = 3'd3,
		ST_TOO_SHORT = 3'd4
	} status_t;

	typedef struct packed {
		logic       id_mismatch;
		logic       value_negative;
		logic [6:0] decimal_exponent;
		logic [31:0] mantissa_value;
		logic [7:0] unit_code;
		status_t    status;
	} result_t;

	localparam int RESULT_W = $bits(result_t);
	localparam int TDATA_W  = ((RESULT_W + 7) / 8) * 8;

endpackage

`default_nettype wire

// ===== rtl/mrrd_frame.sv =====
// ----------------------------------------------------------------------------
// mrrd_frame
// Per-byte field capture of one response frame and result build on its close.
// ----------------------------------------------------------------------------
`default_nettype none

module mrrd_frame (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_take,
	input  wire logic [7:0]        data_byte,
	input  wire logic              last_byte,
	input  wire logic              empty_frame,
	input  wire logic [15:0]       expected_id,
	output logic                   res_valid,
	output mrrd_pkg::result_t      res
);
	import mrrd_pkg::*;

	logic [3:0]  pos_q, pos_n;
	logic        prefix_q, prefix_n;
	logic [15:0] echo_q, echo_n;
	logic [7:0]  unit_q, unit_n;
	logic [7:0]  count_q, count_n;
	logic [7:0]  expo_q, expo_n;
	logic [31:0] acc_q, acc_n;
	logic [3:0]  ui;
	logic [8:0]  need_cur, need_fin;
	logic        too_small;
	logic        mism;
	logic [6:0]  mag;

	always_comb begin
		prefix_n = (pos_q == 4'd0) ? (data_byte == PREFIX_BYTE) : prefix_q;
		ui       = prefix_n ? 4'd3 : 4'd2;
		need_cur = 9'(ui) + 9'd3 + 9'(count_q);

		echo_n = echo_q;
		if (prefix_n && pos_q == 4'd1) begin
			echo_n = {data_byte, echo_q[7:0]};
		end else if (prefix_n && pos_q == 4'd2) begin
			echo_n = {echo_q[15:8], data_byte};
		end

		unit_n  = unit_q;
		count_n = count_q;
		expo_n  = expo_q;
		acc_n   = acc_q;
		priority if (pos_q == ui) begin
			unit_n = data_byte;
		end else if (pos_q == ui + 4'd1) begin
			count_n = data_byte;
		end else if (pos_q == ui + 4'd2) begin
			expo_n = data_byte;
		end else if (pos_q >= ui + 4'd3 && 9'(pos_q) < need_cur) begin
			acc_n = {acc_q[23:0], data_byte};
		end

		pos_n = (pos_q == POS_MAX) ? POS_MAX : pos_q + 4'd1;
	end

	always_comb begin
		need_fin  = 9'(ui) + 9'd3 + 9'(count_n);
		too_small = pos_n < (prefix_n ? 4'd5 : 4'd4);
		mism      = prefix_n && (echo_n != expected_id);
		mag       = {1'b0, expo_n[5:0] & EXP_MAG_MASK[5:0]};

		res = '0;
		if (empty_frame) begin
			res.status = ST_EMPTY;
		end else if (too_small) begin
			res.status = ST_TOO_SMALL;
		end else if (count_n > 8'(MAX_MANTISSA_BYTES)) begin
			res.status      = ST_BAD_COUNT;
			res.id_mismatch = mism;
		end else if (9'(pos_n) < need_fin) begin
			res.status      = ST_TOO_SHORT;
			res.id_mismatch = mism;
		end else begin
			res.status           = ST_OK;
			res.id_mismatch      = mism;
			res.unit_code        = unit_n;
			res.mantissa_value   = acc_n;
			res.decimal_exponent = expo_n[EXP_SIGN_POS] ? 7'(7'd0 - mag) : mag;
			res.value_negative   = expo_n[EXP_NEG_POS];
		end

		res_valid = in_take && (empty_frame || last_byte);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			prefix_q <= 1'b0;
			echo_q   <= '0;
			unit_q   <= '0;
			count_q  <= '0;
			expo_q   <= '0;
			acc_q    <= '0;
		end else if (in_take) begin
			if (empty_frame || last_byte) begin
				pos_q    <= '0;
				prefix_q <= 1'b0;
				echo_q   <= '0;
				unit_q   <= '0;
				count_q  <= '0;
				expo_q   <= '0;
				acc_q    <= '0;
			end else begin
				pos_q    <= pos_n;
				prefix_q <= prefix_n;
				echo_q   <= echo_n;
				unit_q   <= unit_n;
				count_q  <= count_n;
				expo_q   <= expo_n;
				acc_q    <= acc_n;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/mrrd_out_skid.sv =====
// ----------------------------------------------------------------------------
// mrrd_out_skid
// Output register with one skid entry; keeps input ready from the sink.
// ----------------------------------------------------------------------------
`default_nettype none

module mrrd_out_skid (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              res_valid,
	input  wire mrrd_pkg::result_t res,
	output logic                   space,
	output logic                   out_valid,
	output mrrd_pkg::result_t      out_res,
	input  wire logic              out_ready
);
	import mrrd_pkg::*;

	logic    out_valid_q;
	logic    skid_valid_q;
	result_t out_q;
	result_t skid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= res_valid;
			end
		end else if (res_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_ready) begin
			out_q <= skid_valid_q ? skid_q : res;
		end else if (res_valid) begin
			skid_q <= res;
		end
	end

	assign space     = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_res   = out_q;

endmodule

`default_nettype wire

// ===== rtl/meter_register_response_decoder.sv =====
// ----------------------------------------------------------------------------
// meter_register_response_decoder
// Decodes a meter register-read response into unit, mantissa and exponent.
// ----------------------------------------------------------------------------
// Input stream: one payload byte per request on s_axis; tlast marks the final
// byte, tuser flags a frame with no payload (tdata ignored then).
// Output stream: one result per closed frame on m_axis.
// Config: cfg_wr_en writes cfg_wr_data as the expected register id; write it
// only while no frame is open and no result is pending.
// Throughput: one byte per cycle unless stalled; single field-capture stage.
// Results are built combinationally and held in the output or skid register.
// Reset: clears the open frame, the pending results and the expected id.
// Stall: while m_axis_tready is low one more result parks in a skid entry;
// s_axis_tready drops only once that entry holds a result, and rises again
// the cycle after the output register drains into the sink.
// ----------------------------------------------------------------------------
`default_nettype none

module meter_register_response_decoder (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_axis_tvalid,
	output logic                               s_axis_tready,
	input  wire logic [7:0]                    s_axis_tdata,  // data_byte
	input  wire logic                          s_axis_tlast,
	input  wire logic                          s_axis_tuser,  // empty_frame
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	// status, unit_code, mantissa_value, decimal_exponent, value_negative,
	// id_mismatch, zero fill
	output logic [mrrd_pkg::TDATA_W-1:0]       m_axis_tdata,
	input  wire logic                          cfg_wr_en,
	input  wire logic [15:0]                   cfg_wr_data
);
	import mrrd_pkg::*;

	logic [15:0] exp_id_q;
	logic        take;
	logic        res_valid;
	logic        space;
	result_t     res;
	result_t     out_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_id_q <= '0;
		end else if (cfg_wr_en) begin
			exp_id_q <= cfg_wr_data;
		end
	end

	assign s_axis_tready = space;
	assign take          = s_axis_tvalid && space;

	mrrd_frame u_frame (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_take     (take),
		.data_byte   (s_axis_tdata),
		.last_byte   (s_axis_tlast),
		.empty_frame (s_axis_tuser),
		.expected_id (exp_id_q),
		.res_valid   (res_valid),
		.res         (res)
	);

	mrrd_out_skid u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.space     (space),
		.out_valid (m_axis_tvalid),
		.out_res   (out_res),
		.out_ready (m_axis_tready)
	);

	assign m_axis_tdata = TDATA_W'(out_res);

endmodule

`default_nettype wire

// ===== rtl/mrrd_checker.sv =====
// ----------------------------------------------------------------------------
// mrrd_checker
// Port-level checks of the decoder's result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mrrd_checker (
	input wire logic                    clk,
	input wire logic                    arst_n,
	input wire logic                    s_axis_tvalid,
	input wire logic                    s_axis_tready,
	input wire logic                    s_axis_tuser,
	input wire logic                    m_axis_tvalid,
	input wire logic [mrrd_pkg::TDATA_W-1:0] m_axis_tdata
);
	import mrrd_pkg::*;

	logic [2:0] st;
	logic       ok_st;
	logic       quiet_st;

	assign st       = m_axis_tdata[2:0];
	assign ok_st    = (st == ST_OK);
	assign quiet_st = (st == ST_EMPTY) || (st == ST_TOO_SMALL);

	a_status_known: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (st == ST_OK || st == ST_EMPTY || st == ST_TOO_SMALL ||
			st == ST_BAD_COUNT || st == ST_TOO_SHORT))
		else $error("result status out of range");

	a_fields_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !ok_st) |-> (m_axis_tdata[50:3] == '0))
		else $error("value fields set on a failed frame");

	a_no_mismatch: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && quiet_st) |-> !m_axis_tdata[51])
		else $error("id mismatch on empty or too small frame");

	a_exponent_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[49:43] != 7'h40 &&
			m_axis_tdata[TDATA_W-1:RESULT_W] == '0))
		else $error("exponent out of range or fill bits set");

	a_empty_answers: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && s_axis_tuser) |=> m_axis_tvalid)
		else $error("no result after an empty frame");

endmodule

bind meter_register_response_decoder mrrd_checker u_mrrd_checker (.*);

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the meter register response decoder.
// Streams register-read responses byte by byte: well-formed frames with and
// without the id prefix, truncated, oversized-count, long, empty and noise
// frames. Each accepted byte updates a frame predictor; each decoded result
// is compared field by field against the oldest predicted reading. Runs under
// several expected ids and flow-control mixes, including a long sink stall.
// ----------------------------------------------------------------------------

import mrrd_pkg::*;

class reading_scoreboard;
	logic [15:0] wanted_id;
	logic [3:0]  byte_pos;
	logic        prefix_flag;
	logic [15:0] echo_id;
	logic [7:0]  unit_val;
	logic [7:0]  mant_count;
	logic [7:0]  exp_byte;
	logic [31:0] mant_acc;
	result_t     expected_readings[$];
	int          errors;
	int          bytes_seen;
	int          readings_checked;
	int          id_mismatches;
	int          status_seen[5];

	function new();
		wanted_id = '0;
		errors = 0;
		bytes_seen = 0;
		readings_checked = 0;
		id_mismatches = 0;
		foreach (status_seen[i]) status_seen[i] = 0;
		clear_frame();
	endfunction

	function void clear_frame();
		byte_pos = '0;
		prefix_flag = 1'b0;
		echo_id = '0;
		unit_val = '0;
		mant_count = '0;
		exp_byte = '0;
		mant_acc = '0;
	endfunction

	function void note_byte(logic [7:0] b, logic last, logic empty);
		int unsigned unit_at;
		int unsigned need_len;
		int unsigned min_len;
		logic [7:0]  mag;
		result_t     r;
		r = '0;
		if (empty) begin
			r.status = ST_EMPTY;
			expected_readings = {expected_readings, r};
			clear_frame();
			return;
		end
		bytes_seen++;
		if (byte_pos == 0) prefix_flag = (b == PREFIX_BYTE);
		unit_at = prefix_flag ? 3 : 2;
		if (prefix_flag && byte_pos == 1) echo_id[15:8] = b;
		else if (prefix_flag && byte_pos == 2) echo_id[7:0] = b;
		if (byte_pos == unit_at) unit_val = b;
		else if (byte_pos == unit_at + 1) mant_count = b;
		else if (byte_pos == unit_at + 2) exp_byte = b;
		else if (byte_pos >= unit_at + 3 && byte_pos < unit_at + 3 + mant_count)
			mant_acc = {mant_acc[23:0], b};
		if (byte_pos < POS_MAX) byte_pos++;
		if (!last) return;
		need_len = unit_at + 3 + mant_count;
		min_len = prefix_flag ? 5 : 4;
		if (byte_pos < min_len) begin
			r.status = ST_TOO_SMALL;
		end else begin
			r.id_mismatch = prefix_flag && (echo_id != wanted_id);
			if (mant_count > MAX_MANTISSA_BYTES) begin
				r.status = ST_BAD_COUNT;
			end else if (byte_pos < need_len) begin
				r.status = ST_TOO_SHORT;
			end else begin
				mag = exp_byte & EXP_MAG_MASK;
				r.status = ST_OK;
				r.unit_code = unit_val;
				r.mantissa_value = mant_acc;
				r.decimal_exponent = exp_byte[EXP_SIGN_POS] ? 7'(8'd0 - mag) : 7'(mag);
				r.value_negative = exp_byte[EXP_NEG_POS];
			end
		end
		expected_readings = {expected_readings, r};
		clear_frame();
	endfunction

	function void compare_field(string field, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
		end
	endfunction

	function void check_reading(result_t got);
		result_t want;
		if (expected_readings.size() == 0) begin
			errors++;
			$display("%0t: result with nothing pending, expected none, got 0x%0h", $time, got);
			return;
		end
		want = expected_readings.pop_front();
		readings_checked++;
		status_seen[int'(want.status)]++;
		if (want.id_mismatch) id_mismatches++;
		compare_field("status", 32'(want.status), 32'(got.status));
		compare_field("unit_code", 32'(want.unit_code), 32'(got.unit_code));
		compare_field("mantissa_value", want.mantissa_value, got.mantissa_value);
		compare_field("decimal_exponent", 32'(want.decimal_exponent),
			32'(got.decimal_exponent));
		compare_field("value_negative", 32'(want.value_negative), 32'(got.value_negative));
		compare_field("id_mismatch", 32'(want.id_mismatch), 32'(got.id_mismatch));
	endfunction
endclass

module testbench;
	localparam int STALL_LIMIT = 3000;
	localparam int BYTES_PER_PHASE = 425;

	logic               clk;
	logic               arst_n;
	logic               s_axis_tvalid;
	logic               s_axis_tready;
	logic [7:0]         s_axis_tdata;   // data_byte
	logic               s_axis_tlast;
	logic               s_axis_tuser;   // empty_frame
	logic               m_axis_tvalid;
	logic               m_axis_tready;
	// status, unit_code, mantissa_value, decimal_exponent, value_negative,
	// id_mismatch, zero fill
	logic [TDATA_W-1:0] m_axis_tdata;
	logic               cfg_wr_en;
	logic [15:0]        cfg_wr_data;

	reading_scoreboard sb = new();
	logic [7:0]        frame_bytes[$];
	int                sender_idle_pct = 0;
	int                sink_stall_pct = 0;
	int                hold_cycles = 0;
	int                bytes_sent = 0;
	int                no_progress = 0;

	meter_register_response_decoder u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				m_axis_tready <= 1'b0;
				hold_cycles--;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_wr_en) sb.wanted_id = cfg_wr_data;
			if (s_axis_tvalid && s_axis_tready)
				sb.note_byte(s_axis_tdata, s_axis_tlast, s_axis_tuser);
			if (m_axis_tvalid && m_axis_tready)
				sb.check_reading(result_t'(m_axis_tdata[RESULT_W-1:0]));
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_wr_en)
			no_progress <= 0;
		else
			no_progress <= no_progress + 1;
		if (no_progress == STALL_LIMIT) begin
			$display("%0t: no progress for %0d cycles, %0d readings outstanding",
				$time, STALL_LIMIT, sb.expected_readings.size());
			$display("meter_register_response_decoder test failed");
			$finish;
		end
	end

	function automatic void add_byte(input logic [7:0] b);
		frame_bytes = {frame_bytes, b};
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic last, input logic empty);
		while ($urandom_range(99) < sender_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tlast <= last;
		s_axis_tuser <= empty;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_frame();
		foreach (frame_bytes[i])
			send_byte(frame_bytes[i], i == frame_bytes.size() - 1, 1'b0);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.expected_readings.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_expected_id(input logic [15:0] id);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= id;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic send_random_frame();
		int         kind;
		int         count;
		int         extra;
		logic [7:0] lead;
		kind = $urandom_range(99);
		if (kind < 8) begin
			if ($urandom_range(1))
				repeat ($urandom_range(1, 6)) send_byte(8'($urandom), 1'b0, 1'b0);
			send_byte(8'($urandom), 1'($urandom), 1'b1);
			return;
		end
		frame_bytes.delete();
		if ($urandom_range(1)) begin
			add_byte(PREFIX_BYTE);
			if ($urandom_range(99) < 75) begin
				add_byte(sb.wanted_id[15:8]);
				add_byte(sb.wanted_id[7:0]);
			end else begin
				add_byte(8'($urandom));
				add_byte(8'($urandom));
			end
		end else begin
			lead = 8'($urandom);
			if (lead == PREFIX_BYTE) lead = 8'h00;
			add_byte(lead);
			add_byte(8'($urandom));
		end
		add_byte(8'($urandom));
		if (kind < 18) begin
			count = $urandom_range(MAX_MANTISSA_BYTES + 1, 255);
			add_byte(8'(count));
			add_byte(8'($urandom));
			repeat ($urandom_range(0, 6)) add_byte(8'($urandom));
		end else begin
			count = $urandom_range(0, MAX_MANTISSA_BYTES);
			add_byte(8'(count));
			add_byte(8'($urandom));
			repeat (count) add_byte(8'($urandom));
			if (kind < 26) extra = $urandom_range(6, 16);
			else if ($urandom_range(3) == 0) extra = $urandom_range(1, 3);
			else extra = 0;
			repeat (extra) add_byte(8'($urandom));
		end
		if (kind >= 26 && kind < 38) begin
			while (frame_bytes.size() > 1 && $urandom_range(2) != 0) void'(frame_bytes.pop_back());
		end else if (kind >= 38 && kind < 44) begin
			frame_bytes.delete();
			repeat ($urandom_range(1, 20)) add_byte(8'($urandom));
		end
		send_frame();
	endtask

	task automatic run_phase(input logic [15:0] id, input int idle_pct, input int stall_pct,
			input bit long_hold);
		int target;
		write_expected_id(id);
		sender_idle_pct = idle_pct;
		sink_stall_pct = stall_pct;
		if (long_hold) hold_cycles = 300;
		target = bytes_sent + BYTES_PER_PHASE;
		while (bytes_sent < target) send_random_frame();
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		s_axis_tuser = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		write_expected_id(16'h1234);
		send_byte(8'hFF, 1'b1, 1'b1);
		frame_bytes = '{8'h01, 8'h12, 8'h34, 8'h00, 8'h00, 8'h40};
		send_frame();
		frame_bytes = '{8'hFE, 8'h00, 8'hFF, 8'h04, 8'hBF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
		send_frame();
		frame_bytes = '{8'h01};
		send_frame();
		frame_bytes = '{8'h00, 8'hFF, 8'h80, 8'h05};
		send_frame();
		frame_bytes = '{8'h01, 8'hAB, 8'hCD, 8'h00, 8'h02, 8'h7F};
		send_frame();
		send_byte(8'h01, 1'b0, 1'b0);
		send_byte(8'h00, 1'b0, 1'b1);
		drain();

		run_phase(16'hFFFF, 0, 0, 1'b0);
		run_phase(16'h0000, 48, 0, 1'b0);
		run_phase(16'($urandom), 0, 48, 1'b1);
		run_phase(16'($urandom), 37, 37, 1'b0);
		repeat (8) @(posedge clk);

		$display("covered %0d payload bytes and %0d decoded readings over five expected ids",
			sb.bytes_seen, sb.readings_checked);
		$display("readings: ok %0d, empty %0d, too small %0d, bad count %0d, too short %0d,",
			sb.status_seen[ST_OK], sb.status_seen[ST_EMPTY], sb.status_seen[ST_TOO_SMALL],
			sb.status_seen[ST_BAD_COUNT], sb.status_seen[ST_TOO_SHORT]);
		$display("id mismatch %0d", sb.id_mismatches);
		if (sb.errors == 0)
			$display("meter_register_response_decoder test passed");
		else
			$display("meter_register_response_decoder test failed");
		$finish;
	end
endmodule
